// ===== rtl/core/nsm_pkg.sv =====
// shared types and constants for the nfa subset move core
// no dependencies; imported by the core, the match unit and the checker

package nsm_pkg;

    // state ids and symbols carried by one table entry
    localparam int unsigned NSM_SRC_W       = 5;
    localparam int unsigned NSM_SYM_W       = 8;
    localparam int unsigned NSM_SET_W       = 32;
    localparam int unsigned NSM_COUNT_W     = 7;
    localparam int unsigned NSM_IDX_W       = 6;

    // states at or above this id never match
    localparam int unsigned NSM_STATE_COUNT = 32;
    localparam int unsigned NSM_TABLE_DEPTH = 64;

    // item kind carried in s_tuser[0]
    localparam logic NSM_FUNC_LOAD  = 1'b0;
    localparam logic NSM_FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [NSM_SYM_W-1:0] sym;
        logic [NSM_SRC_W-1:0] target;
        logic [NSM_SRC_W-1:0] source;
    } nsm_entry_t;

endpackage

// ===== rtl/core/nsm_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies

module nsm_ram #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 64,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/core/nsm_match.sv =====
// compare unit: tests one transition entry against the current set and symbol
// depends on nsm_pkg

module nsm_match
    import nsm_pkg::*;
(
    input  nsm_entry_t           entry,
    input  logic [NSM_SET_W-1:0] cur_set,
    input  logic [NSM_SYM_W-1:0] cur_sym,
    output logic [NSM_SET_W-1:0] hit_mask
);

    logic src_ok;
    logic tgt_ok;
    logic hit;

    always_comb begin
        src_ok   = (32'(entry.source) < NSM_STATE_COUNT) && cur_set[entry.source];
        tgt_ok   = (32'(entry.target) < NSM_STATE_COUNT);
        hit      = src_ok && tgt_ok && (entry.sym == cur_sym);
        hit_mask = hit ? (NSM_SET_W'(1) << entry.target) : '0;
    end

endmodule

// ===== rtl/core/nfa_subset_move_core.sv =====
// top level of the nfa subset move core: sequencer, table ram and output register
// depends on nsm_pkg, nsm_ram and nsm_match

// usage
//   s_ channel: one beat is a load (s_tuser[0] = 0) that writes one transition
//   entry, or a query (s_tuser[0] = 1) that moves a state set on a symbol.
//   m_ channel: one beat per query, none per load; m_tdata is the reached set,
//   m_tuser flags the dead state (reached set empty or query marked dead).
//   cfg_wr_en / cfg_wr_data set the number of valid table entries; write it
//   only while no query is in flight.
// load and query flow
//   a load is taken while idle; the next beat can follow right away.
//   a query walks the table one entry per cycle through the single ram read
//   port and the shared compare unit, with limit = min(transition count,
//   TABLE_DEPTH); a dead query or a zero limit skips the walk. s_tready is
//   low while a query runs.
// stalls and reset
//   the result waits in an output register; s_ keeps accepting beats while it
//   waits. a later query that finishes holds in its last step until the
//   register frees up.
//   reset clears the transition count and drops all valid flags; the table
//   itself is not cleared, so a query must only reach entries already loaded.

module nfa_subset_move_core
    import nsm_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = NSM_TABLE_DEPTH
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [NSM_COUNT_W-1:0] cfg_wr_data,   // transition_count

    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [5:0] entry_index, [10:6] entry_source, [15:11] entry_target,
    // [23:16] symbol, [55:24] query_set
    input  logic [55:0]            s_tdata,
    // [0] func, [1] query_dead
    input  logic [1:0]             s_tuser,

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [NSM_SET_W-1:0]   m_tdata,       // [31:0] next_set
    output logic                   m_tuser        // [0] next_dead
);

    localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned LIM_W  = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // input beat fields
    logic                 in_func;
    logic                 in_dead;
    logic [NSM_IDX_W-1:0] in_index;
    nsm_entry_t           in_entry;
    logic [NSM_SYM_W-1:0] in_sym;
    logic [NSM_SET_W-1:0] in_set;

    assign in_func         = s_tuser[0];
    assign in_dead         = s_tuser[1];
    assign in_index        = s_tdata[5:0];
    assign in_entry.source = s_tdata[10:6];
    assign in_entry.target = s_tdata[15:11];
    assign in_entry.sym    = s_tdata[23:16];
    assign in_sym          = s_tdata[23:16];
    assign in_set          = s_tdata[55:24];

    // control and work registers
    logic [1:0]             state_reg,   state_next;
    logic [NSM_COUNT_W-1:0] count_reg;
    logic [LIM_W-1:0]       limit_reg,   limit_next;
    logic [LIM_W-1:0]       idx_reg,     idx_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [NSM_SET_W-1:0]   set_reg,     set_next;
    logic [NSM_SYM_W-1:0]   sym_reg,     sym_next;
    logic [NSM_SET_W-1:0]   acc_reg,     acc_next;
    logic                   m_valid_reg, m_valid_next;
    logic [NSM_SET_W-1:0]   m_set_reg,   m_set_next;
    logic                   m_dead_reg,  m_dead_next;

    logic                   s_accept;
    logic                   out_free;
    logic                   issue;
    logic [LIM_W-1:0]       limit_now;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    nsm_entry_t             ram_rdata;
    logic [NSM_SET_W-1:0]   hit_mask;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    // entries scanned: count saturates at the table depth
    assign limit_now = (32'(count_reg) < 32'(TABLE_DEPTH)) ? LIM_W'(count_reg)
                                                            : LIM_W'(TABLE_DEPTH);

    // loads past the table end are dropped
    assign ram_we    = s_accept && (in_func == NSM_FUNC_LOAD)
                       && (32'(in_index) < 32'(TABLE_DEPTH));
    assign ram_waddr = ADDR_W'(32'(in_index));

    // one table read per scan cycle until the index reaches the limit
    assign issue = (state_reg == ST_SCAN) && (idx_reg != limit_reg);

    nsm_ram #(
        .WIDTH ($bits(nsm_entry_t)),
        .DEPTH (TABLE_DEPTH),
        .ADDR_W(ADDR_W)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(in_entry),
        .rd_en  (issue),
        .rd_addr(idx_reg[ADDR_W-1:0]),
        .rd_data(ram_rdata)
    );

    nsm_match u_match (
        .entry   (ram_rdata),
        .cur_set (set_reg),
        .cur_sym (sym_reg),
        .hit_mask(hit_mask)
    );

    always_comb begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        idx_next     = idx_reg;
        rd_pend_next = 1'b0;
        set_next     = set_reg;
        sym_next     = sym_reg;
        acc_next     = acc_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_set_next   = m_set_reg;
        m_dead_next  = m_dead_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (in_func == NSM_FUNC_QUERY)) begin
                    set_next   = in_set;
                    sym_next   = in_sym;
                    acc_next   = '0;
                    idx_next   = '0;
                    limit_next = limit_now;
                    // a dead set moves nowhere and a zero limit has nothing to walk: skip the walk
                    if (in_dead || (limit_now == '0)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_pend_next = issue;
                if (issue) begin
                    idx_next = idx_reg + LIM_W'(1);
                end
                // read data lands in the cycle after its address
                if (rd_pend_reg) begin
                    acc_next = acc_reg | hit_mask;
                end
                if (!issue && !rd_pend_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_set_next   = acc_reg;
                    m_dead_next  = (acc_reg == '0);
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        limit_reg <= limit_next;
        idx_reg   <= idx_next;
        set_reg   <= set_next;
        sym_reg   <= sym_next;
        acc_reg   <= acc_next;
        m_set_reg <= m_set_next;
        m_dead_reg <= m_dead_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_set_reg;
    assign m_tuser  = m_dead_reg;

endmodule

// ===== rtl/core/nsm_checker.sv =====
// port-level checks for the nfa subset move core, bound to the top level
// depends on nsm_pkg and nfa_subset_move_core

module nsm_checker
    import nsm_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [1:0]             s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [NSM_SET_W-1:0]   m_tdata,
    input logic                   m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // dead flag and set agree
    a_dead_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata == '0)))
        else $error("dead flag disagrees with reached set");

    // an accepted query beat drops the input ready
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == NSM_FUNC_QUERY) |=> !s_tready)
        else $error("input ready right after a query beat");

    // a load never blocks the input
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[0] == NSM_FUNC_LOAD) |=> s_tready)
        else $error("input blocked after a load beat");

endmodule

bind nfa_subset_move_core nsm_checker u_nsm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
